// ----- sv/mma_pkg.sv -----
// Shared types and constants of the multichannel moving-average filter.
`default_nettype none
package mma_pkg;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned TAG_W      = 2;
	localparam int unsigned WIN_W      = 7;
	localparam int unsigned N_CHANNELS = 10;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [WIN_W-1:0] win_t;
endpackage
`default_nettype wire

// ----- sv/mma_front.sv -----
// Front end: writes samples into the ring store and queues one request per item.
`default_nettype none
module mma_front #(
	parameter int unsigned MAX_WINDOW = 64,
	parameter int unsigned RING_DEPTH = 128,
	parameter int unsigned CHANNELS   = 10,
	parameter int unsigned SLOT_W     = 7,
	parameter int unsigned CNT_W      = 7
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	output logic                          full,
	input  wire  [CHANNELS*16-1:0]        samples,
	input  wire  [3:0]                    tags,
	input  wire  [mma_pkg::WIN_W-1:0]     window_count,
	// request queue read side
	output logic                          req_valid,
	output logic [CNT_W-1:0]              req_count,
	output logic [SLOT_W-1:0]             req_slot,
	output logic [3:0]                    req_tags,
	input  wire                           req_take,
	// store write port
	output logic                          wr_en,
	output logic [SLOT_W-1:0]             wr_slot,
	output logic [CHANNELS*16-1:0]        wr_data
);
	import mma_pkg::*;

	localparam int unsigned QD = 2;
	localparam int unsigned REQ_W = CNT_W + SLOT_W + 4;

	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  held_q;
	logic [CNT_W-1:0]  win_eff;
	logic [CNT_W-1:0]  held_next;
	logic [REQ_W-1:0]  fifo_q [QD];
	logic              rp_q, wp_q;
	logic [1:0]        cnt_q;
	logic              acc;

	always_comb begin
		if (32'(window_count) > MAX_WINDOW)
			win_eff = CNT_W'(MAX_WINDOW);
		else
			win_eff = CNT_W'(window_count);
		if (held_q >= win_eff)
			held_next = win_eff;
		else
			held_next = held_q + 1'b1;
	end

	assign full = (cnt_q == 2'(QD));
	assign acc  = push && !full;
	assign wr_en   = acc;
	assign wr_slot = slot_q;
	assign wr_data = samples;
	assign req_valid = (cnt_q != 2'd0);
	assign {req_count, req_slot, req_tags} = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			held_q <= '0;
			rp_q   <= 1'b0;
			wp_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				// advance the ring; the slot after the newest is the end of the window
				slot_q <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				held_q <= held_next;
				wp_q   <= ~wp_q;
			end
			if (req_valid && req_take)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(req_valid && req_take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			fifo_q[wp_q] <= {held_next,
				(slot_q == SLOT_W'(RING_DEPTH - 1)) ? SLOT_W'(0) : slot_q + 1'b1, tags};
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QD))
		else $error("request queue overflow");
	a_held_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> held_q <= CNT_W'(MAX_WINDOW))
		else $error("held count above maximum");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !acc)
		else $error("accepted while full");
`endif
endmodule
`default_nettype wire

// ----- sv/mma_back.sv -----
// Back end: sums each channel over the held samples and divides serially.
`default_nettype none
module mma_back #(
	parameter int unsigned RING_DEPTH = 128,
	parameter int unsigned CHANNELS   = 10,
	parameter int unsigned SLOT_W     = 7,
	parameter int unsigned CNT_W      = 7,
	parameter int unsigned CH_W       = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	input  wire  [CNT_W-1:0]       req_count,
	input  wire  [SLOT_W-1:0]      req_slot,
	input  wire  [3:0]             req_tags,
	output logic                   req_take,
	input  wire                    wr_en,
	input  wire  [SLOT_W-1:0]      wr_slot,
	input  wire  [CHANNELS*16-1:0] wr_data,
	output logic                   empty,
	input  wire                    pop,
	output logic [CHANNELS*16-1:0] res_data,
	output logic [3:0]             res_tags
);
	import mma_pkg::*;

	localparam int unsigned SUM_W  = 16 + CNT_W;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_RD = 3'd1, ST_ACC = 3'd2,
		ST_DIV = 3'd3, ST_NEXT = 3'd4, ST_OUT = 3'd5;

	logic [2:0]        state_q;
	logic [CH_W-1:0]   ch_q;
	logic [CNT_W-1:0]  k_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0]        tags_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]  mag_q;
	logic [SUM_W-1:0]  rem_q;
	logic [5:0]        bit_q;
	logic              neg_q;
	logic [CHANNELS*16-1:0] acc_q;
	logic              hold_q;
	sample_t           mem_q [CHANNELS];
	sample_t           rd_q;
	logic [SUM_W:0]    trial;
	logic [SUM_W-1:0]  quo;
	logic [SLOT_W-1:0] prev_slot;
	logic [SLOT_W-1:0] res_slot_base;

	// one channel write per cycle is not enough for all channels, so the store is
	// banked per channel: each bank has one write and one read port
	genvar g;
	for (g = 0; g < CHANNELS; g++) begin : g_bank
		sample_t bank_q [RING_DEPTH];
		sample_t brd_q;
		always_ff @(posedge clk) begin
			if (wr_en)
				bank_q[wr_slot] <= wr_data[g*16 +: 16];
			brd_q <= bank_q[rslot_q];
		end
		assign mem_q[g] = brd_q;
	end

	assign rd_q = mem_q[ch_q];
	assign prev_slot = (rslot_q == '0) ? SLOT_W'(RING_DEPTH - 1) : rslot_q - 1'b1;
	assign trial = {rem_q, mag_q[SUM_W-1]} - {{(SUM_W-CNT_W+1){1'b0}}, cnt_q};
	assign quo = neg_q ? -mag_q : mag_q;
	assign req_take = (state_q == ST_IDLE) && req_valid && !hold_q;
	assign empty = !hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hold_q  <= 1'b0;
		end else begin
			if (hold_q && pop)
				hold_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (req_take) state_q <= (req_count == '0) ? ST_OUT : ST_RD;
				ST_RD:   state_q <= ST_ACC;
				ST_ACC:  state_q <= (k_q == '0) ? ST_DIV : ST_RD;
				ST_DIV:  if (bit_q == '0) state_q <= ST_NEXT;
				ST_NEXT: state_q <= (ch_q == CH_W'(CHANNELS - 1)) ? ST_OUT : ST_RD;
				ST_OUT: if (!hold_q) begin
					hold_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q    <= '0;
				cnt_q   <= req_count;
				k_q     <= req_count;
				tags_q  <= req_tags;
				rslot_q <= (req_slot == '0) ? SLOT_W'(RING_DEPTH - 1) : req_slot - 1'b1;
				sum_q   <= '0;
				acc_q   <= '0;
				res_slot_base <= req_slot;
			end
			ST_RD: begin
				k_q     <= k_q - 1'b1;
			end
			ST_ACC: begin
				sum_q   <= sum_q + SUM_W'(rd_q);
				rslot_q <= prev_slot;
				if (k_q == '0) begin
					neg_q <= sum_q[SUM_W-1] ^ rd_q[15] ? (sum_q + SUM_W'(rd_q)) < 0
						: (sum_q + SUM_W'(rd_q)) < 0;
					mag_q <= ((sum_q + SUM_W'(rd_q)) < 0) ? -(sum_q + SUM_W'(rd_q))
						: (sum_q + SUM_W'(rd_q));
					rem_q <= '0;
					bit_q <= 6'(SUM_W - 1);
				end
			end
			ST_DIV: begin
				// restoring division, one quotient bit a cycle
				if (!trial[SUM_W]) begin
					rem_q <= trial[SUM_W-1:0];
					mag_q <= {mag_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[SUM_W-2:0], mag_q[SUM_W-1]};
					mag_q <= {mag_q[SUM_W-2:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
			end
			ST_NEXT: begin
				acc_q[ch_q*16 +: 16] <= quo[15:0];
				ch_q    <= ch_q + 1'b1;
				k_q     <= cnt_q;
				sum_q   <= '0;
				rslot_q <= (res_slot_base == '0) ? SLOT_W'(RING_DEPTH - 1)
					: res_slot_base - 1'b1;
			end
			ST_OUT: if (!hold_q) begin
				res_data <= acc_q;
				res_tags <= tags_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |-> state_q == ST_IDLE)
		else $error("request taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q && !pop) |=> hold_q)
		else $error("result dropped");
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= CH_W'(CHANNELS - 1) || state_q == ST_IDLE || state_q == ST_OUT)
		else $error("channel index out of range");
`endif
endmodule
`default_nettype wire

// ----- sv/multichannel_moving_average.sv -----
// Top level of the multichannel moving-average filter.
// Usage:
//   Input side is a queue: present a sample set with push; it is taken at a
//   clock edge where push is high and full is low. The front end writes all
//   ten channels into their ring banks at once and queues a request for the
//   back end; up to two requests wait in that queue. The banks hold twice the
//   maximum window, so queued sets never overwrite samples still being read.
//   Result side is a queue: while empty is low the averages and tags are on
//   the ports; pop takes them.
//   Processing: the back end walks each channel, reading and accumulating
//   each stored sample in a read state and an accumulate state, then runs a
//   serial divide and stores the quotient in a separate state. One item at
//   a time is processed, and the next request starts only once the previous
//   result has been popped.
//   window_count is written on cfg_we and applies to the next item; values
//   above the maximum act as the maximum, zero gives zero averages.
//   Reset clears the ring position, held count and queues; window resets to 8.
//   When the receiver stalls, the finished result holds and the back end
//   waits; input keeps being accepted until the request queue is full.
`default_nettype none
module multichannel_moving_average #(
	parameter int unsigned MAX_WINDOW = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [15:0] quat_x, quat_y, quat_z, quat_w,
	input  wire  [15:0] accel_x, accel_y, accel_z,
	input  wire  [15:0] gyro_x, gyro_y, gyro_z,
	input  wire  [1:0]  arm_tag,
	input  wire  [1:0]  direction_tag,
	input  wire         cfg_we,
	input  wire  [mma_pkg::WIN_W-1:0] cfg_data,
	output logic        empty,
	input  wire         pop,
	output logic [15:0] avg_quat_x, avg_quat_y, avg_quat_z, avg_quat_w,
	output logic [15:0] avg_accel_x, avg_accel_y, avg_accel_z,
	output logic [15:0] avg_gyro_x, avg_gyro_y, avg_gyro_z,
	output logic [1:0]  arm_out,
	output logic [1:0]  direction_out
);
	import mma_pkg::*;

	// twice the window: room for the sets queued behind the one being averaged
	localparam int unsigned RING_DEPTH = 2 * MAX_WINDOW;
	localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int unsigned CH_W   = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;

	logic [WIN_W-1:0] win_q;
	logic [N_CHANNELS*SAMPLE_W-1:0] samples, res_data, wr_data;
	logic [3:0] res_tags, req_tags;
	logic req_valid, req_take, wr_en;
	logic [CNT_W-1:0] req_count;
	logic [SLOT_W-1:0] req_slot, wr_slot;

	assign samples = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x,
		quat_w, quat_z, quat_y, quat_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= WIN_W'(8);
		else if (cfg_we)
			win_q <= cfg_data;
	end

	mma_front #(.MAX_WINDOW(MAX_WINDOW), .RING_DEPTH(RING_DEPTH), .CHANNELS(N_CHANNELS),
		.SLOT_W(SLOT_W), .CNT_W(CNT_W))
	u_front (
		.clk, .arst_n, .push, .full, .samples, .tags({direction_tag, arm_tag}),
		.window_count(win_q), .req_valid, .req_count, .req_slot, .req_tags,
		.req_take, .wr_en, .wr_slot, .wr_data
	);

	mma_back #(.RING_DEPTH(RING_DEPTH), .CHANNELS(N_CHANNELS), .SLOT_W(SLOT_W),
		.CNT_W(CNT_W), .CH_W(CH_W))
	u_back (
		.clk, .arst_n, .req_valid, .req_count, .req_slot, .req_tags, .req_take,
		.wr_en, .wr_slot, .wr_data, .empty, .pop, .res_data, .res_tags
	);

	assign {avg_gyro_z, avg_gyro_y, avg_gyro_x, avg_accel_z, avg_accel_y, avg_accel_x,
		avg_quat_w, avg_quat_z, avg_quat_y, avg_quat_x} = res_data;
	assign {direction_out, arm_out} = res_tags;
endmodule
`default_nettype wire
